### hw/rtl/ura_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_pkg
// Shared types, constants and lookup tables for the ultrasonic range alert.
// ----------------------------------------------------------------------------
package ura_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int LAST_W         = 16;
	localparam int RANGE_W        = 4;
	localparam int HALF_W         = 10;
	localparam int TPM_W          = 16;
	localparam int CPCM_W         = 8;
	localparam int CFG_W          = 16;
	localparam int THR_W          = 16;
	localparam int NUM_THR        = 10;

	localparam logic [TPM_W-1:0]   TICKS_PER_MS_RST  = 16'd1000;
	localparam logic [CPCM_W-1:0]  COUNTS_PER_CM_RST = 8'd58;
	localparam logic [RANGE_W-1:0] RANGE_MAX         = 4'd11;

	// configuration register indexes
	localparam logic REG_TICKS_PER_MS  = 1'b0;
	localparam logic REG_COUNTS_PER_CM = 1'b1;

	typedef enum logic [1:0] {
		COL_RED   = 2'd0,
		COL_BLUE  = 2'd1,
		COL_GREEN = 2'd2
	} color_t;

	typedef logic [CPCM_W-1:0] thr_cm_t [NUM_THR];

	localparam thr_cm_t THRESH_CM = '{
		8'd10, 8'd25, 8'd50, 8'd75, 8'd100, 8'd120, 8'd140, 8'd160, 8'd180, 8'd200
	};

	typedef struct packed {
		logic                 changed;
		logic [RANGE_W-1:0]   range_idx;
		logic [LAST_W-1:0]    last_count;
	} meas_t;

	typedef struct packed {
		logic red;
		logic blue;
		logic green;
	} led_t;

	typedef struct packed {
		led_t                 led;
		meas_t                meas;
	} res_t;

	function automatic color_t range_color(input logic [RANGE_W-1:0] r);
		color_t c;
		unique case (r)
			4'd6, 4'd7, 4'd8, 4'd9, 4'd10: c = COL_BLUE;
			4'd11:                         c = COL_GREEN;
			default:                       c = COL_RED;
		endcase
		return c;
	endfunction

	// blink half period in ms; zero means steady
	function automatic logic [HALF_W-1:0] range_half(input logic [RANGE_W-1:0] r);
		logic [HALF_W-1:0] h;
		unique case (r)
			4'd2:    h = 10'd200;
			4'd3:    h = 10'd300;
			4'd4:    h = 10'd400;
			4'd5:    h = 10'd500;
			4'd6:    h = 10'd100;
			4'd7:    h = 10'd200;
			4'd8:    h = 10'd300;
			4'd9:    h = 10'd400;
			4'd10:   h = 10'd500;
			4'd11:   h = 10'd1000;
			default: h = 10'd0;
		endcase
		return h;
	endfunction

endpackage

### hw/rtl/ura_pulse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_pulse
// Echo edge detection, pulse width counter and range classification.
// ----------------------------------------------------------------------------
module ura_pulse
	import ura_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              echo,
	input  logic [CPCM_W-1:0] counts_per_cm,
	output meas_t             meas
);

	localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

	logic                  prev_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [LAST_W-1:0]     latched_q;
	logic [RANGE_W-1:0]    range_q;
	logic [THR_W-1:0]      thr_q [NUM_THR];

	logic                  rise;
	logic                  fall;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [CMP_W-1:0]      cnt_ext;
	logic [NUM_THR-1:0]    below;
	logic [RANGE_W-1:0]    cls_range;

	assign rise    = echo & ~prev_q;
	assign fall    = ~echo & prev_q;
	assign cnt_ext = CMP_W'(cnt_q);

	always_comb begin
		priority if (rise) begin
			cnt_d = COUNT_BITS'(1);
		end else if (echo) begin
			cnt_d = cnt_q + COUNT_BITS'(1);
		end else begin
			cnt_d = cnt_q;
		end
	end

	// thresholds are ascending, so the lowest one above the count wins
	always_comb begin
		for (int i = 0; i < NUM_THR; i++) begin
			below[i] = cnt_ext < CMP_W'(thr_q[i]);
		end
		cls_range = RANGE_MAX;
		for (int i = NUM_THR - 1; i >= 0; i--) begin
			if (below[i]) begin
				cls_range = RANGE_W'(i + 1);
			end
		end
	end

	always_comb begin
		meas.changed    = fall && (cls_range != range_q);
		meas.range_idx  = fall ? cls_range : range_q;
		meas.last_count = fall ? cnt_ext[LAST_W-1:0] : latched_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 1'b0;
			cnt_q     <= '0;
			latched_q <= '0;
			range_q   <= '0;
		end else if (step) begin
			prev_q    <= echo;
			cnt_q     <= cnt_d;
			latched_q <= meas.last_count;
			range_q   <= meas.range_idx;
		end
	end

	// scaled thresholds follow the config register in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_THR; i++) begin
				thr_q[i] <= THR_W'(THRESH_CM[i]) * THR_W'(COUNTS_PER_CM_RST);
			end
		end else begin
			for (int i = 0; i < NUM_THR; i++) begin
				thr_q[i] <= THR_W'(THRESH_CM[i]) * THR_W'(counts_per_cm);
			end
		end
	end

endmodule

### hw/rtl/ura_blink.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ura_blink
// Millisecond divider, blink phase timer and LED color decode.
// ----------------------------------------------------------------------------
module ura_blink
	import ura_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               changed,
	input  logic [RANGE_W-1:0] range_idx,
	input  logic [TPM_W-1:0]   ticks_per_ms,
	output led_t               led
);

	logic [TPM_W-1:0]  sub_q;
	logic [HALF_W-1:0] phase_q;
	logic              off_q;

	logic [TPM_W-1:0]  sub_d;
	logic [HALF_W-1:0] phase_d;
	logic              off_d;
	logic [HALF_W-1:0] half;
	color_t            color;
	logic [TPM_W-1:0]  limit;
	logic [TPM_W:0]    sub_inc;
	logic [HALF_W:0]   phase_inc;

	assign half      = range_half(range_idx);
	assign color     = range_color(range_idx);
	assign limit     = (ticks_per_ms == '0) ? TPM_W'(1) : ticks_per_ms;
	assign sub_inc   = {1'b0, sub_q} + (TPM_W + 1)'(1);
	assign phase_inc = {1'b0, phase_q} + (HALF_W + 1)'(1);

	always_comb begin
		sub_d   = sub_q;
		phase_d = phase_q;
		off_d   = off_q;
		priority if (changed || (half == '0)) begin
			sub_d   = '0;
			phase_d = '0;
			off_d   = 1'b0;
		end else if (sub_inc >= {1'b0, limit}) begin
			sub_d = '0;
			if (phase_inc >= {1'b0, half}) begin
				phase_d = '0;
				off_d   = ~off_q;
			end else begin
				phase_d = phase_inc[HALF_W-1:0];
			end
		end else begin
			sub_d = sub_inc[TPM_W-1:0];
		end
	end

	always_comb begin
		if (half == '0) begin
			led = '{red: 1'b1, blue: 1'b0, green: 1'b0};
		end else begin
			led.red   = !off_d && (color == COL_RED);
			led.blue  = !off_d && (color == COL_BLUE);
			led.green = !off_d && (color == COL_GREEN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q   <= '0;
			phase_q <= '0;
			off_q   <= 1'b0;
		end else if (step) begin
			sub_q   <= sub_d;
			phase_q <= phase_d;
			off_q   <= off_d;
		end
	end

endmodule

### hw/rtl/ultrasonic_range_alert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_alert_unit
// Echo pulse width ranging with an LED range alert, one result per tick.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake             Payload
//  in       in   in_valid / in_stall   echo_level
//  out      out  out_valid / out_stall red_on blue_on green_on range_index
//                                      range_changed last_pulse_count
//  cfg      in   cfg_we                cfg_idx cfg_wdata
//
//  One tick per cycle while the output is not stalled; each result passes the
//  input register, then the result register.
//  Reset clears all counters, range and blink state; config returns to
//  1000 ticks/ms and 58 counts/cm.
//  A stalled result holds; the input register keeps taking ticks while the
//  result register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module ultrasonic_range_alert_unit
	import ura_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               echo_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               red_on,
	output logic               blue_on,
	output logic               green_on,
	output logic [RANGE_W-1:0] range_index,
	output logic               range_changed,
	output logic [LAST_W-1:0]  last_pulse_count,
	input  logic               cfg_we,
	input  logic               cfg_idx,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	logic [TPM_W-1:0]  tpm_q;
	logic [CPCM_W-1:0] cpcm_q;

	logic  valid_s1;
	logic  echo_s1;
	logic  valid_s2;
	res_t  res_s2;

	logic  out_free;
	logic  step;
	meas_t meas;
	led_t  led;

	assign out_free = !valid_s2 || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q  <= TICKS_PER_MS_RST;
			cpcm_q <= COUNTS_PER_CM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TICKS_PER_MS:  tpm_q  <= cfg_wdata[TPM_W-1:0];
				REG_COUNTS_PER_CM: cpcm_q <= cfg_wdata[CPCM_W-1:0];
				default:           tpm_q  <= tpm_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			echo_s1 <= echo_level;
		end
	end

	ura_pulse #(
		.COUNT_BITS(COUNT_BITS)
	) u_pulse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.echo         (echo_s1),
		.counts_per_cm(cpcm_q),
		.meas         (meas)
	);

	ura_blink u_blink (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.changed     (meas.changed),
		.range_idx   (meas.range_idx),
		.ticks_per_ms(tpm_q),
		.led         (led)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2.led  <= led;
			res_s2.meas <= meas;
		end
	end

	assign out_valid        = valid_s2;
	assign red_on           = res_s2.led.red;
	assign blue_on          = res_s2.led.blue;
	assign green_on         = res_s2.led.green;
	assign range_index      = res_s2.meas.range_idx;
	assign range_changed    = res_s2.meas.changed;
	assign last_pulse_count = res_s2.meas.last_count;

	a_led_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({red_on, blue_on, green_on}))
		else $error("more than one LED lit");

	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> range_index <= RANGE_MAX)
		else $error("range index out of bounds");

	a_change_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_changed |-> range_index != '0)
		else $error("range change to the no-measurement range");

	a_steady_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (range_index == 4'd0 || range_index == 4'd1)
			|-> red_on && !blue_on && !green_on)
		else $error("steady range not showing red");

endmodule

### verif/ultrasonic_range_alert_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_alert_unit_tb
// Drives echo ticks and register writes into the range alert unit. A tracker
// class predicts the LED and range outputs of every tick and checks each
// result transfer in order. Covers threshold edges at several scales, the
// steady ranges, blink toggles, zero-valued registers, random idling on both
// channels and a long output hold-off.
// ----------------------------------------------------------------------------
module ultrasonic_range_alert_unit_tb;
	import ura_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int HOLD_CYCLES  = 64;
	localparam int PRESSURE_AT  = 300;
	localparam int RAND_TICKS   = 420;
	localparam int CALM_TAIL    = 150;

	class led_alert_tracker;
		bit [TPM_W-1:0]          tpm;
		bit [CPCM_W-1:0]         cpcm;
		bit                      prev_lvl;
		bit [COUNT_BITS_DEF-1:0] width_cnt;
		bit [LAST_W-1:0]         latched;
		bit [RANGE_W-1:0]        rng;
		bit [15:0]               sub_ms;
		bit [HALF_W-1:0]         ms;
		bit                      dark;
		res_t                    pending[$];
		int                      errors;

		function new();
			tpm  = TICKS_PER_MS_RST;
			cpcm = COUNTS_PER_CM_RST;
		endfunction

		static function int bound_cm(int i);
			case (i)
				0: return 10;
				1: return 25;
				2: return 50;
				3: return 75;
				4: return 100;
				5: return 120;
				6: return 140;
				7: return 160;
				8: return 180;
				default: return 200;
			endcase
		endfunction

		static function int half_ms(bit [RANGE_W-1:0] r);
			case (r)
				2, 7:    return 200;
				3, 8:    return 300;
				4, 9:    return 400;
				5, 10:   return 500;
				6:       return 100;
				11:      return 1000;
				default: return 0;
			endcase
		endfunction

		static function color_t color_of(bit [RANGE_W-1:0] r);
			if (r == RANGE_MAX)
				return COL_GREEN;
			if (r >= 6)
				return COL_BLUE;
			return COL_RED;
		endfunction

		function bit [RANGE_W-1:0] classify(bit [COUNT_BITS_DEF-1:0] cnt);
			for (int i = 0; i < 10; i++) begin
				if (int'(cnt) < bound_cm(i) * int'(cpcm))
					return RANGE_W'(i + 1);
			end
			return RANGE_MAX;
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_TICKS_PER_MS:  tpm  = val[TPM_W-1:0];
				REG_COUNTS_PER_CM: cpcm = val[CPCM_W-1:0];
			endcase
		endfunction

		function void note_tick(bit lvl);
			res_t             e;
			bit               chg;
			bit [RANGE_W-1:0] r;
			int               half;
			int               lim;
			color_t           col;
			chg = 1'b0;
			if (lvl && !prev_lvl) begin
				width_cnt = 1;
			end else if (lvl) begin
				width_cnt = width_cnt + 1'b1;
			end else if (prev_lvl) begin
				latched = width_cnt;
				r = classify(width_cnt);
				if (r != rng) begin
					rng = r;
					chg = 1'b1;
				end
			end
			prev_lvl = lvl;

			half = half_ms(rng);
			lim  = (tpm == 0) ? 1 : int'(tpm);
			// a new range or a steady range restarts the blink in its lit phase
			if (chg || half == 0) begin
				sub_ms = 0;
				ms     = 0;
				dark   = 1'b0;
			end else if (int'(sub_ms) + 1 >= lim) begin
				sub_ms = 0;
				if (int'(ms) + 1 >= half) begin
					ms   = 0;
					dark = !dark;
				end else begin
					ms = ms + 1'b1;
				end
			end else begin
				sub_ms = sub_ms + 1'b1;
			end

			col = color_of(rng);
			e.led.red        = (half == 0) || (!dark && col == COL_RED);
			e.led.blue       = (half != 0) && !dark && col == COL_BLUE;
			e.led.green      = (half != 0) && !dark && col == COL_GREEN;
			e.meas.changed   = chg;
			e.meas.range_idx = rng;
			e.meas.last_count = latched;
			pending.push_back(e);
		endfunction

		function void cmp(string name, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$error("result transfer with no tick pending: range_index %0d",
					got.meas.range_idx);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("red_on", e.led.red, got.led.red);
			cmp("blue_on", e.led.blue, got.led.blue);
			cmp("green_on", e.led.green, got.led.green);
			cmp("range_index", e.meas.range_idx, got.meas.range_idx);
			cmp("range_changed", e.meas.changed, got.meas.changed);
			cmp("last_pulse_count", e.meas.last_count, got.meas.last_count);
		endfunction
	endclass

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               echo_level = 1'b0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic               red_on;
	logic               blue_on;
	logic               green_on;
	logic [RANGE_W-1:0] range_index;
	logic               range_changed;
	logic [LAST_W-1:0]  last_pulse_count;
	logic               cfg_we     = 1'b0;
	logic               cfg_idx    = REG_TICKS_PER_MS;
	logic [CFG_W-1:0]   cfg_wdata  = '0;

	led_alert_tracker tracker = new();
	int  results_seen = 0;
	int  ticks_sent   = 0;
	int  cycles       = 0;
	bit  calm         = 1'b0;
	bit  tx_gappy     = 1'b1;

	ultrasonic_range_alert_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.echo_level       (echo_level),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.red_on           (red_on),
		.blue_on          (blue_on),
		.green_on         (green_on),
		.range_index      (range_index),
		.range_changed    (range_changed),
		.last_pulse_count (last_pulse_count),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_wdata        (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic send_tick(input logic lvl);
		int gap;
		if (!calm && tx_gappy && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		echo_level <= lvl;
		do @(posedge clk); while (in_stall);
		tracker.note_tick(lvl);
		ticks_sent++;
		if ($urandom_range(0, 99) == 0)
			tx_gappy = !tx_gappy;
	endtask

	task automatic echo_pulse(input int width, input int gap);
		repeat (width) send_tick(1'b1);
		repeat (gap) send_tick(1'b0);
	endtask

	// quiet the input, then wait until every tick has come back out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// upper byte of the counts_per_cm write is junk the block must drop
	task automatic set_config(input logic [TPM_W-1:0] tpm, input logic [CPCM_W-1:0] cpcm);
		write_reg(REG_TICKS_PER_MS, tpm);
		write_reg(REG_COUNTS_PER_CM, {8'($urandom), cpcm});
	endtask

	// output side: random stall bursts plus one long hold-off
	initial begin : rx_drive
		int hold;
		bit gappy;
		bit pressed;
		logic nxt;
		hold    = 0;
		gappy   = 1'b1;
		pressed = 1'b0;
		forever begin
			@(negedge clk);
			if (!pressed && results_seen >= PRESSURE_AT) begin
				pressed = 1'b1;
				hold    = HOLD_CYCLES;
			end
			if (hold > 0) begin
				nxt = 1'b1;
				hold--;
			end else if (!calm && gappy && $urandom_range(0, 5) == 0) begin
				nxt  = 1'b1;
				hold = $urandom_range(0, 5);
			end else begin
				nxt = 1'b0;
			end
			if ($urandom_range(0, 149) == 0)
				gappy = !gappy;
			out_stall <= nxt;
		end
	end

	initial begin : rx_check
		res_t got;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.led.red         = red_on;
				got.led.blue        = blue_on;
				got.led.green       = green_on;
				got.meas.changed    = range_changed;
				got.meas.range_idx  = range_index;
				got.meas.last_count = last_pulse_count;
				tracker.check_result(got);
				results_seen++;
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("ultrasonic_range_alert_unit_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		int start;
		int n;
		int k;
		int lo;
		int hi;
		int w;
		int gap;
		logic [TPM_W-1:0]  tpm;
		logic [CPCM_W-1:0] cpcm;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: idle, then pulses in the steady near range
		repeat (4) send_tick(1'b0);
		echo_pulse(3, 4);
		echo_pulse(1, 2);
		drain();

		// one count per cm: both sides of the low thresholds
		set_config(16'd1, 8'd1);
		for (int i = 0; i < 4; i++) begin
			echo_pulse(led_alert_tracker::bound_cm(i) - 1, 3);
			echo_pulse(led_alert_tracker::bound_cm(i), 3);
		end
		// shortest blink half period, dwell long enough for two toggles
		echo_pulse(100, 205);
		drain();

		// zero in both registers: every tick is a ms, every pulse is the far range
		set_config(16'd0, 8'd0);
		echo_pulse(1, 13);
		echo_pulse(2, 4);
		drain();

		// widest settings with short pulses
		calm = 1'b1;
		set_config(16'hFFFF, 8'd255);
		echo_pulse(40, 3);
		echo_pulse(41, 3);
		calm = 1'b0;

		start = ticks_sent;
		while (ticks_sent - start < RAND_TICKS) begin
			drain();
			case ($urandom_range(0, 5))
				0: tpm = 16'd0;
				1: tpm = 16'd1;
				2: tpm = 16'($urandom_range(2, 6));
				3: tpm = 16'($urandom_range(1, 3));
				4: tpm = 16'hFFFF;
				default: tpm = TICKS_PER_MS_RST;
			endcase
			case ($urandom_range(0, 4))
				0: cpcm = 8'd0;
				1: cpcm = 8'd1;
				2: cpcm = 8'd2;
				3: cpcm = 8'($urandom_range(1, 3));
				default: cpcm = 8'd255;
			endcase
			set_config(tpm, cpcm);
			n = $urandom_range(3, 8);
			repeat (n) begin
				if (ticks_sent - start >= RAND_TICKS - CALM_TAIL)
					calm = 1'b1;
				if ($urandom_range(0, 4) != 0) begin
					k  = $urandom_range(0, 10);
					lo = (k == 0) ? 1 : led_alert_tracker::bound_cm(k - 1) * int'(cpcm);
					if (lo < 1)
						lo = 1;
					hi = (k == 10) ? lo + 30 : led_alert_tracker::bound_cm(k) * int'(cpcm) - 1;
					if (hi < lo)
						hi = lo;
					case ($urandom_range(0, 2))
						0: w = lo;
						1: w = hi;
						default: w = $urandom_range(lo, hi);
					endcase
					if (w > 260)
						w = $urandom_range(1, 260);
					gap = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 300)
						: $urandom_range(1, 12);
					echo_pulse(w, gap);
				end else begin
					// glitchy echo
					repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 1));
				end
			end
		end

		drain();
		repeat (6) @(posedge clk);
		if (tracker.pending.size() == 0 && tracker.errors == 0) begin
			$display("ultrasonic_range_alert_unit_tb: done, clean");
		end else begin
			$display("ultrasonic_range_alert_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
